FILE: hdl/nnd_pkg.sv
// ----------------------------------------------------------------------------
// nnd_pkg - shared constants for the nearest-neighbor downscaler
// Register map, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package nnd_pkg;

  // width of the configuration registers and of one BGRA pixel
  localparam int unsigned CFG_W = 14;
  localparam int unsigned PIX_W = 32;

  // default largest supported frame side
  localparam int unsigned MAX_DIM_DEF = 8192;

  // APB: three registers in 32-bit words at byte addresses 0, 4, 8
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LONG   = 2'd2;

endpackage : nnd_pkg

`default_nettype wire

FILE: hdl/nearest_neighbor_downscaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler - nearest-neighbor frame downscaler
// Drops source pixels so that the long side of a frame fits a configured limit.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one BGRA source pixel per request, raster order.
//  - m_axis carries the kept pixels; tlast marks the last pixel of an output
//    row, tuser the last pixel of the output frame.
//  - APB registers: 0x0 src_width, 0x4 src_height, 0x8 max_long_side.
//    Write them only between frames or while the stream is quiet; a write
//    drops any frame setup that was already computed.
//  - Throughput: one pixel per cycle inside a frame while m_axis does not
//    stall. The first pixel of each frame waits in front of s_axis while
//    the frame geometry is computed by one shared bit-serial divider,
//    which runs the output width, output height and step (long/limit)
//    divisions in turn.
//  - Latency: a kept pixel shows on m_axis the cycle after it is taken.
//  - A single output register holds a pending result; when the receiver
//    stalls, s_axis keeps taking pixels only while that register is free
//    or being emptied in the same cycle.
//  - Reset clears the position to the start of a frame and restores the
//    registers to width 1, height 1, limit 0 (pass-through).
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_downscaler #(
  parameter int unsigned MAX_DIM = nnd_pkg::MAX_DIM_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // source pixel stream
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [nnd_pkg::PIX_W-1:0]      s_axis_tdata,   // [31:0] src_pixel
  // kept pixel stream
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [nnd_pkg::PIX_W-1:0]      m_axis_tdata,   // [31:0] out_pixel
  output logic                           m_axis_tlast,   // end_of_line
  output logic                           m_axis_tuser,   // [0] end_of_frame
  // configuration
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [nnd_pkg::APB_AW-1:0]     paddr,
  input  wire  [nnd_pkg::APB_DW-1:0]     pwdata,
  output logic [nnd_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int unsigned DW    = $clog2(MAX_DIM + 1);  // dimension / counter
  localparam int unsigned NW    = 2 * DW;               // dividend
  localparam int unsigned RW    = 2 * DW;               // accumulator remainder
  localparam int unsigned IW    = 2 * DW + 1;           // kept index
  localparam int unsigned CNT_W = $clog2(NW + 1);
  localparam int unsigned CW    = nnd_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_RUN,
    S_PREP,
    S_MUL,
    S_DIV,
    S_STORE
  } state_e;

  typedef enum logic [1:0] {
    OP_WIDTH,
    OP_HEIGHT,
    OP_STEP
  } op_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0] src_width_q, src_height_q, max_long_q;
  logic          cfg_wr;
  logic [nnd_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[nnd_pkg::REG_IDX_W+1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= CW'(1);
      src_height_q <= CW'(1);
      max_long_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        nnd_pkg::REG_SRC_WIDTH:  src_width_q  <= pwdata[CW-1:0];
        nnd_pkg::REG_SRC_HEIGHT: src_height_q <= pwdata[CW-1:0];
        nnd_pkg::REG_MAX_LONG:   max_long_q   <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      nnd_pkg::REG_SRC_WIDTH:  prdata = nnd_pkg::APB_DW'(src_width_q);
      nnd_pkg::REG_SRC_HEIGHT: prdata = nnd_pkg::APB_DW'(src_height_q);
      nnd_pkg::REG_MAX_LONG:   prdata = nnd_pkg::APB_DW'(max_long_q);
      default:                 prdata = '0;
    endcase
  end

  // live effective sizes: zero counts as one, clamp to MAX_DIM
  logic [DW-1:0] w_live, h_live, lim_live, long_live;
  logic          pass_live;

  always_comb begin
    if (src_width_q == '0)                 w_live = DW'(1);
    else if (32'(src_width_q) > 32'(MAX_DIM))  w_live = DW'(MAX_DIM);
    else                                   w_live = DW'(src_width_q);

    if (src_height_q == '0)                h_live = DW'(1);
    else if (32'(src_height_q) > 32'(MAX_DIM)) h_live = DW'(MAX_DIM);
    else                                   h_live = DW'(src_height_q);

    if (32'(max_long_q) > 32'(MAX_DIM))    lim_live = DW'(MAX_DIM);
    else                                   lim_live = DW'(max_long_q);

    long_live = (w_live > h_live) ? w_live : h_live;
    pass_live = (lim_live == '0) || (long_live <= lim_live);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e        state_q;
  op_e           op_q;
  logic          prep_q;          // geometry ready for the pending frame start
  logic          pass_q;
  logic [DW-1:0] w_q, h_q, lim_q, long_q;   // sizes latched for the divider
  logic [DW-1:0] out_w_q, out_h_q, step_q_q, step_r_q;

  // shared divider
  logic [NW-1:0]    dvd_q;        // dividend, quotient shifts in at the bottom
  logic [DW-1:0]    dvs_q;
  logic [DW-1:0]    rem_q;
  logic [CNT_W-1:0] cnt_q;

  // stream position
  logic [DW-1:0] col_q, row_q, oc_q, orow_q;
  logic [IW-1:0] kc_q, kr_q;
  logic [RW-1:0] crem_q, rrem_q;

  // output register
  logic                      m_valid_q, m_last_q, m_user_q;
  logic [nnd_pkg::PIX_W-1:0] m_data_q;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

  // --------------------------------------------------------------------------
  // Divider step and multiplier operand select
  // --------------------------------------------------------------------------
  logic [DW:0]   div_shift;
  logic          div_ge;
  logic [DW-1:0] div_rem_d;
  logic [DW-1:0] quot;
  logic [NW-1:0] mul_a;
  logic [NW-1:0] mul_p;

  always_comb begin
    div_shift = {rem_q, dvd_q[NW-1]};
    div_ge    = div_shift >= {1'b0, dvs_q};
    div_rem_d = div_ge ? DW'(div_shift - {1'b0, dvs_q}) : DW'(div_shift);
    quot      = dvd_q[DW-1:0];
    mul_a     = (op_q == OP_WIDTH) ? NW'(w_q) : NW'(h_q);
    mul_p     = mul_a * NW'(lim_q);
  end

  // --------------------------------------------------------------------------
  // Pixel path
  // --------------------------------------------------------------------------
  logic          col_wrap, frame_start, need_prep, take;
  logic [DW:0]   row_t;
  logic [DW-1:0] col_a, row_a;
  logic [DW-1:0] oc_e, orow_e;
  logic [IW-1:0] kc_e, kr_e, kc_clamp, kr_clamp;
  logic [RW-1:0] crem_e, rrem_e;
  logic [RW:0]   c_sum, r_sum;
  logic          c_carry, r_carry;
  logic          hit, emit, eol, eof;
  logic [DW:0]   col_inc, row_inc, oc_inc, orow_inc;

  logic [DW-1:0] col_d, row_d, oc_d, orow_d;
  logic [IW-1:0] kc_d, kr_d;
  logic [RW-1:0] crem_d, rrem_d;

  always_comb begin
    // wrap with the live size before use
    col_wrap    = col_q >= w_live;
    row_t       = col_wrap ? ({1'b0, row_q} + (DW+1)'(1)) : {1'b0, row_q};
    row_a       = (row_t >= {1'b0, h_live}) ? '0 : DW'(row_t);
    col_a       = col_wrap ? '0 : col_q;
    frame_start = (col_a == '0) && (row_a == '0);
    need_prep   = frame_start && !prep_q;

    oc_e   = frame_start ? '0 : oc_q;
    orow_e = frame_start ? '0 : orow_q;
    kc_e   = frame_start ? '0 : kc_q;
    kr_e   = frame_start ? '0 : kr_q;
    crem_e = frame_start ? '0 : crem_q;
    rrem_e = frame_start ? '0 : rrem_q;

    kc_clamp = (kc_e >= IW'(w_live)) ? IW'(w_live - DW'(1)) : kc_e;
    kr_clamp = (kr_e >= IW'(h_live)) ? IW'(h_live - DW'(1)) : kr_e;

    // column and row accumulators: index += long/limit
    c_sum   = {1'b0, crem_e} + (RW+1)'(step_r_q);
    c_carry = (lim_live != '0) && (c_sum >= (RW+1)'(lim_live));
    r_sum   = {1'b0, rrem_e} + (RW+1)'(step_r_q);
    r_carry = (lim_live != '0) && (r_sum >= (RW+1)'(lim_live));

    col_inc  = {1'b0, col_a} + (DW+1)'(1);
    row_inc  = {1'b0, row_a} + (DW+1)'(1);
    oc_inc   = {1'b0, oc_e} + (DW+1)'(1);
    orow_inc = {1'b0, orow_e} + (DW+1)'(1);

    hit = (IW'(col_a) == kc_clamp) && (IW'(row_a) == kr_clamp)
          && (orow_e < out_h_q) && (oc_e < out_w_q);

    oc_d   = oc_e;
    orow_d = orow_e;
    kc_d   = kc_e;
    kr_d   = kr_e;
    crem_d = crem_e;
    rrem_d = rrem_e;
    emit   = 1'b0;
    eol    = 1'b0;
    eof    = 1'b0;

    if (pass_q) begin
      emit = 1'b1;
      eol  = col_inc >= {1'b0, w_live};
      eof  = eol && (row_inc >= {1'b0, h_live});
    end else if (hit) begin
      emit   = 1'b1;
      eol    = oc_inc >= {1'b0, out_w_q};
      oc_d   = DW'(oc_inc);
      kc_d   = IW'(kc_e + IW'(step_q_q) + IW'(c_carry));
      crem_d = c_carry ? RW'(c_sum - (RW+1)'(lim_live)) : RW'(c_sum);
      if (eol) begin
        oc_d   = '0;
        kc_d   = '0;
        crem_d = '0;
        orow_d = DW'(orow_inc);
        kr_d   = IW'(kr_e + IW'(step_q_q) + IW'(r_carry));
        rrem_d = r_carry ? RW'(r_sum - (RW+1)'(lim_live)) : RW'(r_sum);
        eof    = orow_inc >= {1'b0, out_h_q};
      end
    end

    // advance the source position
    if (col_inc >= {1'b0, w_live}) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_live}) ? '0 : DW'(row_inc);
    end else begin
      col_d = DW'(col_inc);
      row_d = row_a;
    end

    s_axis_tready = (state_q == S_RUN) && !need_prep
                    && (!m_valid_q || m_axis_tready);
    take = s_axis_tvalid && s_axis_tready;
  end

  // --------------------------------------------------------------------------
  // Sequencer, position state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RUN;
      op_q      <= OP_WIDTH;
      prep_q    <= 1'b0;
      pass_q    <= 1'b0;
      w_q       <= '0;
      h_q       <= '0;
      lim_q     <= '0;
      long_q    <= '0;
      out_w_q   <= '0;
      out_h_q   <= '0;
      step_q_q  <= '0;
      step_r_q  <= '0;
      dvd_q     <= '0;
      dvs_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      oc_q      <= '0;
      orow_q    <= '0;
      kc_q      <= '0;
      kr_q      <= '0;
      crem_q    <= '0;
      rrem_q    <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      m_user_q  <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // output register
      if (take && emit) begin
        m_valid_q <= 1'b1;
        m_data_q  <= s_axis_tdata;
        m_last_q  <= eol;
        m_user_q  <= eof;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (take) begin
        col_q  <= col_d;
        row_q  <= row_d;
        oc_q   <= oc_d;
        orow_q <= orow_d;
        kc_q   <= kc_d;
        kr_q   <= kr_d;
        crem_q <= crem_d;
        rrem_q <= rrem_d;
      end

      if (cfg_wr) begin
        // new sizes: any computed or running frame setup is stale
        prep_q  <= 1'b0;
        state_q <= S_RUN;
      end else begin
        unique case (state_q)
          S_RUN: begin
            if (need_prep) begin
              state_q <= S_PREP;
            end else if (take && frame_start) begin
              // setup consumed by the first pixel of the frame
              prep_q <= 1'b0;
            end
          end
          S_PREP: begin
            w_q    <= w_live;
            h_q    <= h_live;
            lim_q  <= lim_live;
            long_q <= long_live;
            pass_q <= pass_live;
            if (pass_live) begin
              out_w_q  <= w_live;
              out_h_q  <= h_live;
              step_q_q <= DW'(1);
              step_r_q <= '0;
              prep_q   <= 1'b1;
              state_q  <= S_RUN;
            end else begin
              op_q    <= OP_WIDTH;
              state_q <= S_MUL;
            end
          end
          S_MUL: begin
            if (op_q == OP_STEP) begin
              dvd_q <= NW'(long_q);
              dvs_q <= lim_q;
            end else begin
              dvd_q <= mul_p;
              dvs_q <= long_q;
            end
            rem_q   <= '0;
            cnt_q   <= CNT_W'(NW);
            state_q <= S_DIV;
          end
          S_DIV: begin
            dvd_q <= {dvd_q[NW-2:0], div_ge};
            rem_q <= div_rem_d;
            cnt_q <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= S_STORE;
            end
          end
          S_STORE: begin
            unique case (op_q)
              OP_WIDTH: begin
                out_w_q <= (quot == '0) ? DW'(1) : quot;
                op_q    <= OP_HEIGHT;
                state_q <= S_MUL;
              end
              OP_HEIGHT: begin
                out_h_q <= (quot == '0) ? DW'(1) : quot;
                op_q    <= OP_STEP;
                state_q <= S_MUL;
              end
              OP_STEP: begin
                step_q_q <= quot;
                step_r_q <= rem_q;
                prep_q   <= 1'b1;
                state_q  <= S_RUN;
              end
              default: state_q <= S_RUN;
            endcase
          end
          default: state_q <= S_RUN;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // partial remainder of the shared divider stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  // a finished frame setup never yields an empty output frame
  a_geom_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_q |-> ((out_w_q != '0) && (out_h_q != '0)))
    else $error("zero output size after frame setup");

  // in scaled mode the step is at least one and its remainder below the limit
  a_step_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prep_q && !pass_q) |-> ((step_q_q != '0) && (step_r_q < lim_q)))
    else $error("step quotient or remainder out of range");
`endif

endmodule : nearest_neighbor_downscaler

`default_nettype wire

FILE: sim/nearest_neighbor_downscaler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler_test - self-checking bench for the downscaler
// Streams BGRA pixels into the block under random source gaps and sink
// stalls. Between phases, while the stream is quiet, it rewrites the frame
// registers over APB. Every kept pixel, with its tlast (end of line) and
// tuser (end of frame) marks, is checked against an in-bench predictor.
// ----------------------------------------------------------------------------

module nearest_neighbor_downscaler_test;

  localparam int unsigned MAX_SIDE      = nnd_pkg::MAX_DIM_DEF;
  localparam int unsigned PIXEL_TARGET  = 1950;
  // Worst case is a frame setup on every pixel, plus stalls.
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned IDLE_PCT      = 28;
  // A kept pixel shows the cycle after it is taken; allow some margin.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 10;

  // One kept pixel as it should leave the block.
  typedef struct packed {
    logic [nnd_pkg::PIX_W-1:0] pixel;
    logic                      eol;
    logic                      eof;
  } kept_pixel_t;

  typedef enum logic {PLAN_WRITE, PLAN_PIXEL} plan_kind_e;

  // One row of stimulus: a register write or a pixel. Typed rows carry the
  // expected outcome; the others are checked against the predictor.
  typedef struct packed {
    plan_kind_e                    kind;
    logic [nnd_pkg::REG_IDX_W-1:0] reg_idx;
    logic [nnd_pkg::CFG_W-1:0]     value;
    logic [nnd_pkg::PIX_W-1:0]     pixel;
    logic                          typed;
    logic                          has_out;
    logic                          eol;
    logic                          eof;
  } plan_row_t;

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [nnd_pkg::PIX_W-1:0]  s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [nnd_pkg::PIX_W-1:0]  m_axis_tdata;
  logic                       m_axis_tlast;
  logic                       m_axis_tuser;
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [nnd_pkg::APB_AW-1:0] paddr         = '0;
  logic [nnd_pkg::APB_DW-1:0] pwdata        = '0;
  logic [nnd_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  nearest_neighbor_downscaler #(
    .MAX_DIM(MAX_SIDE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor state. Registers are kept at their 14-bit width; positions and
  // accumulators are 32 bits so that a limit changed mid-frame cannot wrap
  // them early.
  // --------------------------------------------------------------------------
  logic [nnd_pkg::CFG_W-1:0] cfg_width, cfg_height, cfg_limit;
  int unsigned src_col, src_row, out_col, out_row;
  int unsigned kept_col, kept_row, col_rem, row_rem;
  int unsigned frame_w, frame_h, step_q, step_r;
  bit          copy_frame;

  kept_pixel_t kept_queue[$];
  kept_pixel_t want;

  int unsigned sent, checked, mismatches, writes, frames_started, cycle_count;

  // a side of 0 counts as 1, anything above the maximum as the maximum
  function automatic int unsigned side_of(input logic [nnd_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return 32'(v);
  endfunction

  // live limit, clamped; 0 means no scaling
  function automatic int unsigned limit_now();
    return (cfg_limit > MAX_SIDE) ? MAX_SIDE : 32'(cfg_limit);
  endfunction

  function automatic int unsigned shrink_side(input int unsigned side,
                                              input int unsigned lim,
                                              input int unsigned longest);
    longint unsigned prod;
    prod = (longint'(side) * longint'(lim)) / longint'(longest);
    return (prod == 0) ? 1 : 32'(prod);
  endfunction

  // Frame geometry is latched when a pixel lands on source position (0,0).
  task automatic latch_frame();
    int unsigned w, h, lim, longest;
    w = side_of(cfg_width);
    h = side_of(cfg_height);
    lim = limit_now();
    longest = (w > h) ? w : h;
    out_col = 0;
    out_row = 0;
    kept_col = 0;
    kept_row = 0;
    col_rem = 0;
    row_rem = 0;
    frames_started++;
    if (lim == 0 || longest <= lim) begin
      copy_frame = 1'b1;
      frame_w = w;
      frame_h = h;
      step_q = 1;
      step_r = 0;
    end else begin
      copy_frame = 1'b0;
      frame_w = shrink_side(w, lim, longest);
      frame_h = shrink_side(h, lim, longest);
      step_q = longest / lim;
      step_r = longest % lim;
    end
  endtask

  // next kept source index: adds long/limit as quotient plus remainder,
  // the remainder compared against the live limit
  task automatic advance_kept(inout int unsigned idx, inout int unsigned rem);
    idx += step_q;
    rem += step_r;
    if (limit_now() != 0 && rem >= limit_now()) begin
      rem -= limit_now();
      idx += 1;
    end
  endtask

  task automatic predict_pixel(input logic [nnd_pkg::PIX_W-1:0] pix, output bit has_out,
                               output kept_pixel_t res);
    int unsigned w, h, kc, kr;
    w = side_of(cfg_width);
    h = side_of(cfg_height);
    has_out = 1'b0;
    res = '0;
    // the source wrap follows the live registers, so a shrunk size wraps here
    if (src_col >= w) begin
      src_col = 0;
      src_row += 1;
    end
    if (src_row >= h) src_row = 0;
    if (src_col == 0 && src_row == 0) latch_frame();

    if (copy_frame) begin
      res.pixel = pix;
      res.eol = (src_col + 1 >= w);
      res.eof = (src_col + 1 >= w) && (src_row + 1 >= h);
      has_out = 1'b1;
    end else if (out_row < frame_h && out_col < frame_w) begin
      // kept index never points past the source edge
      kc = (kept_col >= w) ? w - 1 : kept_col;
      kr = (kept_row >= h) ? h - 1 : kept_row;
      if (src_col == kc && src_row == kr) begin
        res.pixel = pix;
        out_col += 1;
        advance_kept(kept_col, col_rem);
        res.eol = (out_col >= frame_w);
        res.eof = 1'b0;
        if (res.eol) begin
          out_col = 0;
          kept_col = 0;
          col_rem = 0;
          out_row += 1;
          advance_kept(kept_row, row_rem);
          res.eof = (out_row >= frame_h);
        end
        has_out = 1'b1;
      end
    end
    // once the output frame is complete, the rest of the frame is dropped

    src_col += 1;
    if (src_col >= w) begin
      src_col = 0;
      src_row += 1;
      if (src_row >= h) src_row = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Idling: both sides stall about 28 percent of the time, except for one
  // stretch of the random part where traffic runs back to back.
  // --------------------------------------------------------------------------
  function automatic bit quiet_stretch();
    return (sent >= 700 && sent < 1000);
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= quiet_stretch() || ($urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Result checker: each kept pixel against the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (kept_queue.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel %08h eol %0b eof %0b",
                                m_axis_tdata, m_axis_tlast, m_axis_tuser));
      end else begin
        want = kept_queue[0];
        kept_queue.delete(0);
        if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.eol ||
            m_axis_tuser !== want.eof) begin
          note_mismatch($sformatf(
            "kept pixel %0d: expected %08h eol %0b eof %0b, got %08h eol %0b eof %0b",
            checked, want.pixel, want.eol, want.eof,
            m_axis_tdata, m_axis_tlast, m_axis_tuser));
        end
        checked++;
      end
    end
  end

  // Watchdog: ends a hung run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("nearest_neighbor_downscaler_test: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers. All drive on the falling edge; handshakes are seen on the rising.
  // --------------------------------------------------------------------------

  // Sends one pixel request; tvalid stays high on return so that back-to-back
  // requests need no second assignment in the same step.
  task automatic send_pixel(input plan_row_t row);
    bit          has_out;
    kept_pixel_t res;
    while (!quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= row.pixel;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pixel(row.pixel, has_out, res);
    if (row.typed) begin
      has_out = row.has_out;
      res.pixel = row.pixel;
      res.eol = row.eol;
      res.eof = row.eof;
    end
    if (has_out) kept_queue.insert(kept_queue.size(), res);
    sent++;
    @(negedge clk_i);
  endtask

  // Source pauses until every expected pixel is out, then waits out SETTLE_CYCLES
  // in case a pixel that keeps nothing is still inside.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (kept_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [nnd_pkg::REG_IDX_W-1:0] idx,
                           input logic [nnd_pkg::CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= nnd_pkg::APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      nnd_pkg::REG_SRC_WIDTH:  cfg_width = value;
      nnd_pkg::REG_SRC_HEIGHT: cfg_height = value;
      nnd_pkg::REG_MAX_LONG:   cfg_limit = value;
      default: ;
    endcase
    writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus table helpers
  // --------------------------------------------------------------------------
  function automatic plan_row_t write_row(input logic [nnd_pkg::REG_IDX_W-1:0] idx,
                                          input logic [nnd_pkg::CFG_W-1:0] value);
    plan_row_t row;
    row = '0;
    row.kind = PLAN_WRITE;
    row.reg_idx = idx;
    row.value = value;
    return row;
  endfunction

  function automatic plan_row_t pixel_row(input logic [nnd_pkg::PIX_W-1:0] pix);
    plan_row_t row;
    row = '0;
    row.kind = PLAN_PIXEL;
    row.pixel = pix;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic [nnd_pkg::PIX_W-1:0] pix,
                                          input bit has_out,
                                          input bit eol, input bit eof);
    plan_row_t row;
    row = pixel_row(pix);
    row.typed = 1'b1;
    row.has_out = has_out;
    row.eol = eol;
    row.eof = eof;
    return row;
  endfunction

  plan_row_t plan[$];

  // appends one row to the stimulus table
  function automatic void add_row(input plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [nnd_pkg::CFG_W-1:0] w_new, h_new, l_new, tmp;
    int unsigned               w_eff, h_eff, count, pick, phase;

    // predictor matches the block's reset: 1x1 frames, no scaling
    cfg_width = 14'd1;
    cfg_height = 14'd1;
    cfg_limit = 14'd0;
    {src_col, src_row, out_col, out_row} = '0;
    {kept_col, kept_row, col_rem, row_rem} = '0;
    {frame_w, frame_h, step_q, step_r} = '0;
    copy_frame = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // after reset every pixel is a whole 1x1 frame
    add_row(typed_row(32'h0000_0000, 1'b1, 1'b1, 1'b1));
    add_row(typed_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    // 3x2 into a limit of 2: 2x1 out, second source row dropped
    add_row(write_row(nnd_pkg::REG_SRC_WIDTH, 14'd3));
    add_row(write_row(nnd_pkg::REG_SRC_HEIGHT, 14'd2));
    add_row(write_row(nnd_pkg::REG_MAX_LONG, 14'd2));
    add_row(pixel_row(32'h1122_3344));
    add_row(pixel_row(32'h5566_7788));
    add_row(pixel_row(32'h99AA_BBCC));
    add_row(pixel_row(32'hDDEE_FF00));
    add_row(pixel_row(32'h0F0F_0F0F));
    add_row(pixel_row(32'hF0F0_F0F0));
    // zero sizes count as 1: 1x1 within the limit, copied
    add_row(write_row(nnd_pkg::REG_SRC_WIDTH, 14'd0));
    add_row(write_row(nnd_pkg::REG_SRC_HEIGHT, 14'd0));
    add_row(typed_row(32'hA5A5_5A5A, 1'b1, 1'b1, 1'b1));
    // oversize width clamps to the maximum; limit 1 keeps only pixel (0,0),
    // and the next pixel of that frame keeps nothing
    add_row(write_row(nnd_pkg::REG_SRC_WIDTH, 14'h3FFF));
    add_row(write_row(nnd_pkg::REG_MAX_LONG, 14'd1));
    add_row(typed_row(32'h8000_0001, 1'b1, 1'b1, 1'b1));
    add_row(typed_row(32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0));
    // width cut mid-frame: position is past the new edge and wraps at once,
    // starting a 1x1 frame that fits the limit
    add_row(write_row(nnd_pkg::REG_SRC_WIDTH, 14'd1));
    add_row(typed_row(32'h3C3C_C3C3, 1'b1, 1'b1, 1'b1));
    // 8x1 at limit 4 keeps columns 0,2,4,6; cutting the width to 4 after
    // column 2 clamps the next kept column to the new edge
    add_row(write_row(nnd_pkg::REG_SRC_WIDTH, 14'd8));
    add_row(write_row(nnd_pkg::REG_MAX_LONG, 14'd4));
    add_row(pixel_row(32'h0000_00FF));
    add_row(pixel_row(32'h0000_FF00));
    add_row(pixel_row(32'h00FF_0000));
    add_row(write_row(nnd_pkg::REG_SRC_WIDTH, 14'd4));
    add_row(pixel_row(32'hFF00_0000));
    // 4x1 at limit 4: long side fits exactly, copied
    add_row(pixel_row(32'h1357_9BDF));
    add_row(pixel_row(32'h2468_ACE0));
    add_row(pixel_row(32'hFEDC_BA98));
    add_row(pixel_row(32'h7654_3210));
    // oversize limit clamps to the maximum: 2x2 copied
    add_row(write_row(nnd_pkg::REG_MAX_LONG, 14'h3FFF));
    add_row(write_row(nnd_pkg::REG_SRC_HEIGHT, 14'd2));
    add_row(write_row(nnd_pkg::REG_SRC_WIDTH, 14'd2));
    add_row(pixel_row(32'hCAFE_0001));
    add_row(pixel_row(32'hCAFE_0002));
    add_row(pixel_row(32'hCAFE_0003));
    add_row(pixel_row(32'hCAFE_0004));

    foreach (plan[i]) begin
      if (plan[i].kind == PLAN_WRITE) begin
        wait_drained();
        apb_write(plan[i].reg_idx, plan[i].value);
      end else begin
        send_pixel(plan[i]);
      end
    end

    // ---- random part ----
    // Mostly whole frames of small size; now and then a frame with one side
    // at the maximum, sent only in part so the next writes may wrap it mid-frame.
    phase = 0;
    while (sent < PIXEL_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        w_new = $urandom_range(1) ? nnd_pkg::CFG_W'(MAX_SIDE) : 14'h3FFF;
        h_new = nnd_pkg::CFG_W'($urandom_range(1, 3));
        l_new = nnd_pkg::CFG_W'($urandom_range(1, 8));
        if ($urandom_range(1)) begin
          tmp = w_new;
          w_new = h_new;
          h_new = tmp;
        end
      end else begin
        w_new = nnd_pkg::CFG_W'($urandom_range(0, 12));
        h_new = nnd_pkg::CFG_W'($urandom_range(0, 12));
        pick = $urandom_range(99);
        if (pick < 20) l_new = '0;
        else if (pick < 25) l_new = $urandom_range(1) ? 14'h3FFF : nnd_pkg::CFG_W'(MAX_SIDE);
        else l_new = nnd_pkg::CFG_W'($urandom_range(1, 14));
      end

      // registers only change while nothing is in flight
      wait_drained();
      if (phase == 0 || $urandom_range(99) < 70) apb_write(nnd_pkg::REG_SRC_WIDTH, w_new);
      if (phase == 0 || $urandom_range(99) < 70) apb_write(nnd_pkg::REG_SRC_HEIGHT, h_new);
      if (phase == 0 || $urandom_range(99) < 70) apb_write(nnd_pkg::REG_MAX_LONG, l_new);

      w_eff = side_of(cfg_width);
      h_eff = side_of(cfg_height);
      if (w_eff * h_eff > 1024) begin
        count = $urandom_range(20, 150);
      end else begin
        count = $urandom_range(1, 3) * w_eff * h_eff;
        if ($urandom_range(3) == 0) count += $urandom_range(0, w_eff * h_eff - 1);
      end
      // keep the total close to the target
      if (count > PIXEL_TARGET - sent) count = PIXEL_TARGET - sent;

      for (int i = 0; i < count; i++) begin
        // hold the source until the sink has caught up, at least once
        if (i == count / 2 && (phase == 2 || $urandom_range(9) == 0)) wait_drained();
        send_pixel(pixel_row($urandom));
      end
      phase++;
    end

    wait_drained();
    repeat (10) @(negedge clk_i);

    $display("covered %0d pixels in %0d frame starts over %0d register writes",
             sent, frames_started, writes);
    $display("%0d kept pixels checked, %0d mismatches, %0d cycles",
             checked, mismatches, cycle_count);
    if (mismatches == 0 && kept_queue.size() == 0) begin
      $display("nearest_neighbor_downscaler_test: done, clean");
    end else begin
      $display("nearest_neighbor_downscaler_test: done, errors");
    end
    $finish;
  end

endmodule
